>>> design/bpt_pkg.sv
// Shared types and constants of the burst penalty tracker.
`default_nettype none

package bpt_pkg;

   typedef enum logic [1:0] {
      CMD_UPDATE,
      CMD_RESTART,
      CMD_CLONE,
      CMD_RESET
   } cmd_type;

   typedef enum logic [2:0] {
      CSR_SCORE_ENABLE,
      CSR_EXCLUDE_KTHREAD,
      CSR_SHIFT_RISE,
      CSR_SHIFT_FALL,
      CSR_PENALTY_OFFSET,
      CSR_PENALTY_SCALE
   } csr_index_type;

   localparam logic [7:0]  MAX_PENALTY   = 8'd156;
   localparam logic [5:0]  PRIO_CAP      = 6'd39;
   localparam logic [6:0]  RST_OFFSET    = 7'd24;
   localparam logic [11:0] RST_SCALE     = 12'd1280;
   localparam int          PROD_SHIFT    = 16;

   // One task entry of the penalty table.
   typedef struct packed {
      logic [7:0] history;
      logic [7:0] current;
      logic [7:0] penalty;
      logic [5:0] score;
   } entry_type;

   typedef struct packed {
      logic capture;
      logic clear_write;
      logic mem_write;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic out_busy;
   } ctrl_stat_type;

endpackage

`default_nettype wire

>>> design/bpt_if.sv
// Channel interfaces of the burst penalty tracker: request, response and register write.
`default_nettype none

interface bpt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [5:0]  task_index;
   logic [63:0] burst_ns;
   logic [5:0]  nice_index;
   logic        is_kernel_thread;

   modport source (output valid, output cmd, output task_index, output burst_ns,
                   output nice_index, output is_kernel_thread, input ready);
   modport sink (input valid, input cmd, input task_index, input burst_ns,
                 input nice_index, input is_kernel_thread, output ready);
endinterface

interface bpt_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] penalty;
   logic [5:0] score;
   logic [5:0] effective_priority;
   logic       priority_changed;

   modport source (output valid, output penalty, output score, output effective_priority,
                   output priority_changed, input ready);
   modport sink (input valid, input penalty, input score, input effective_priority,
                 input priority_changed, output ready);
endinterface

interface bpt_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [11:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> design/bpt_ctrl.sv
// Sequencing state machine of the burst penalty tracker.
`default_nettype none

module bpt_ctrl
   import bpt_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire ctrl_stat_type stat,
   output ctrl_cmd_type       cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LZ,
      ST_MSB,
      ST_FRAC,
      ST_MUL,
      ST_APPLY
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, req_ready_in;

   always_comb begin
      cmd.capture     = req_valid && req_ready_ff;
      cmd.clear_write = (state_ff == ST_CLEAR);
      cmd.mem_write   = (state_ff == ST_APPLY) && !stat.out_busy;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (stat.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (cmd.capture) state_in = ST_LZ;
         end
         ST_LZ:    state_in = ST_MSB;
         ST_MSB:   state_in = ST_FRAC;
         ST_FRAC:  state_in = ST_MUL;
         ST_MUL:   state_in = ST_APPLY;
         ST_APPLY: begin
            if (!stat.out_busy) state_in = ST_IDLE;
         end
         default:  state_in = ST_CLEAR;
      endcase
      req_ready_in = (state_in == ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         req_ready_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= req_ready_in;
      end
   end

   assign req_ready = req_ready_ff;

`ifndef SYNTH
   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready_ff |-> state_ff == ST_IDLE)
      else $error("request ready outside the idle state");

   a_capture_starts_work: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> state_ff == ST_LZ && !req_ready_ff)
      else $error("accepted beat did not start processing");

   a_clear_blocks_requests: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_ready_ff)
      else $error("request ready while the table is being cleared");
`endif

endmodule

`default_nettype wire

>>> design/bpt_datapath.sv
// Datapath of the burst penalty tracker: registers, log2 unit, multiplier and task table.
`default_nettype none

module bpt_datapath
   import bpt_pkg::*;
#(
   parameter int NUM_TASKS = 64
) (
   input  wire logic   clock,
   input  wire logic   reset,
   bpt_req_if.sink     req,
   bpt_rsp_if.source   rsp,
   bpt_csr_if.sink     csr,
   input  wire ctrl_cmd_type cmd,
   output ctrl_stat_type stat
);

   localparam int TASK_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

   // Configuration registers.
   logic        score_enable_ff;
   logic        excl_kthread_ff;
   logic        shift_rise_ff;
   logic        shift_fall_ff;
   logic [6:0]  offset_ff;
   logic [11:0] scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         score_enable_ff <= 1'b1;
         excl_kthread_ff <= 1'b1;
         shift_rise_ff   <= 1'b1;
         shift_fall_ff   <= 1'b0;
         offset_ff       <= RST_OFFSET;
         scale_ff        <= RST_SCALE;
      end else if (csr.valid) begin
         case (csr_index_type'(csr.index))
            CSR_SCORE_ENABLE:    score_enable_ff <= csr.data[0];
            CSR_EXCLUDE_KTHREAD: excl_kthread_ff <= csr.data[0];
            CSR_SHIFT_RISE:      shift_rise_ff   <= csr.data[0];
            CSR_SHIFT_FALL:      shift_fall_ff   <= csr.data[0];
            CSR_PENALTY_OFFSET:  offset_ff       <= csr.data[6:0];
            CSR_PENALTY_SCALE:   scale_ff        <= csr.data;
            default: ;
         endcase
      end
   end

   assign csr.ready = 1'b1;

   // Task index folding into the table depth, worked out at elaboration.
   logic [TASK_W-1:0] idx_map [64];

   for (genvar k = 0; k < 64; k++) begin : g_idx_map
      assign idx_map[k] = TASK_W'(k % NUM_TASKS);
   end

   // Captured request beat.
   cmd_type           cmd_ff;
   logic [TASK_W-1:0] idx_ff;
   logic [63:0]       burst_ff;
   logic [5:0]        nice_ff;
   logic              kthread_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff     <= cmd_type'(req.cmd);
         idx_ff     <= idx_map[req.task_index];
         burst_ff   <= req.burst_ns;
         nice_ff    <= req.nice_index;
         kthread_ff <= req.is_kernel_thread;
      end
   end

   // Leading-one search, first step: one position per byte.
   logic [7:0] grp_nz_in, grp_nz_ff;
   logic [2:0] grp_pos_in [8];
   logic [2:0] grp_pos_ff [8];

   always_comb begin
      for (int g = 0; g < 8; g++) begin
         grp_nz_in[g]  = |burst_ff[g*8 +: 8];
         grp_pos_in[g] = 3'd0;
         for (int b = 0; b < 8; b++) begin
            if (burst_ff[g*8 + b]) grp_pos_in[g] = 3'(b);
         end
      end
   end

   // Second step: the highest nonzero byte gives the bit count.
   logic [6:0] msb1_in, msb1_ff;

   always_comb begin
      msb1_in = 7'd0;
      for (int g = 0; g < 8; g++) begin
         if (grp_nz_ff[g]) msb1_in = 7'({3'(g), grp_pos_ff[g]}) + 7'd1;
      end
   end

   // Third step: eight fraction bits below the leading one, then the offset.
   logic [5:0]  lead;
   logic [71:0] burst_ext;
   logic [7:0]  frac;
   logic [14:0] greed;
   logic [14:0] tol;
   logic [14:0] pen_in, pen_ff;

   always_comb begin
      lead      = 6'(msb1_ff - 7'd1);
      burst_ext = {burst_ff, 8'd0};
      frac      = burst_ext[lead +: 8];
      greed     = (msb1_ff == 7'd0) ? 15'd0 : {msb1_ff, frac};
      tol       = {offset_ff, 8'd0};
      pen_in    = (greed > tol) ? 15'(greed - tol) : 15'd0;
   end

   // Fourth step: scaling product.
   logic [26:0] prod_ff;

   always_ff @(posedge clock) begin
      grp_nz_ff <= grp_nz_in;
      grp_pos_ff <= grp_pos_in;
      msb1_ff   <= msb1_in;
      pen_ff    <= pen_in;
      prod_ff   <= 27'(pen_ff) * 27'(scale_ff);
   end

   // Task table.
   entry_type         mem [NUM_TASKS];
   entry_type         rd_entry_ff;
   logic [TASK_W-1:0] clr_addr_ff;
   logic              wr_en;
   logic [TASK_W-1:0] wr_addr;
   entry_type         wr_data;
   entry_type         new_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear_write) begin
         clr_addr_ff <= clr_addr_ff + TASK_W'(1);
      end
   end

   always_comb begin
      wr_en   = cmd.clear_write || cmd.mem_write;
      wr_addr = cmd.clear_write ? clr_addr_ff : idx_ff;
      wr_data = cmd.clear_write ? '0 : new_entry;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_entry_ff <= mem[idx_ff];
   end

   // Final step: clamp, table update and priority.
   logic [10:0] scaled;
   logic [7:0]  cur_pen;
   logic [7:0]  smoothed;
   logic [7:0]  upd_pen;
   logic [5:0]  kept_score;
   logic [6:0]  prio_before;
   logic [6:0]  prio_after;
   logic [5:0]  eff_before;
   logic [5:0]  eff_after;

   always_comb begin
      scaled  = prod_ff[PROD_SHIFT +: 11];
      cur_pen = (scaled < 11'(MAX_PENALTY)) ? scaled[7:0] : MAX_PENALTY;
      upd_pen = (rd_entry_ff.history > cur_pen) ? rd_entry_ff.history : cur_pen;

      // Rising and falling increments use separate shifts.
      if (rd_entry_ff.current >= rd_entry_ff.history) begin
         smoothed = rd_entry_ff.history +
                    ((rd_entry_ff.current - rd_entry_ff.history) >> shift_rise_ff);
      end else begin
         smoothed = rd_entry_ff.history -
                    ((rd_entry_ff.history - rd_entry_ff.current) >> shift_fall_ff);
      end

      new_entry = rd_entry_ff;
      case (cmd_ff)
         CMD_UPDATE: begin
            new_entry.current = cur_pen;
            new_entry.penalty = upd_pen;
         end
         CMD_RESTART, CMD_CLONE: begin
            new_entry.history = smoothed;
            new_entry.current = 8'd0;
            new_entry.penalty = smoothed;
         end
         default: new_entry = '0;
      endcase

      kept_score = (kthread_ff && excl_kthread_ff) ? 6'd0 : new_entry.penalty[7:2];
      if (cmd_ff == CMD_UPDATE || cmd_ff == CMD_RESTART) new_entry.score = kept_score;

      prio_before = 7'(nice_ff) + (score_enable_ff ? 7'(rd_entry_ff.score) : 7'd0);
      prio_after  = 7'(nice_ff) + (score_enable_ff ? 7'(new_entry.score) : 7'd0);
      eff_before  = (prio_before < 7'(PRIO_CAP)) ? prio_before[5:0] : PRIO_CAP;
      eff_after   = (prio_after < 7'(PRIO_CAP)) ? prio_after[5:0] : PRIO_CAP;
   end

   // Response register.
   logic       rsp_valid_ff;
   logic [7:0] rsp_pen_ff;
   logic [5:0] rsp_score_ff;
   logic [5:0] rsp_eff_ff;
   logic       rsp_chg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.mem_write) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_write) begin
         rsp_pen_ff   <= new_entry.penalty;
         rsp_score_ff <= new_entry.score;
         rsp_eff_ff   <= eff_after;
         rsp_chg_ff   <= (eff_after != eff_before);
      end
   end

   assign rsp.valid              = rsp_valid_ff;
   assign rsp.penalty            = rsp_pen_ff;
   assign rsp.score              = rsp_score_ff;
   assign rsp.effective_priority = rsp_eff_ff;
   assign rsp.priority_changed   = rsp_chg_ff;

   always_comb begin
      stat.clear_done = cmd.clear_write && (clr_addr_ff == TASK_W'(NUM_TASKS - 1));
      stat.out_busy   = rsp_valid_ff && !rsp.ready;
   end

`ifndef SYNTH
   a_rsp_from_write: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.mem_write))
      else $error("response beat appeared without a table write");

   a_no_write_during_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_write |-> !cmd.clear_write && !stat.out_busy)
      else $error("table update collided with clearing or a stalled response");

   a_rsp_ranges: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_eff_ff <= PRIO_CAP && rsp_pen_ff <= MAX_PENALTY)
      else $error("response beat out of range");
`endif

endmodule

`default_nettype wire

>>> design/burst_penalty_tracker_top.sv
// Top level of the burst penalty tracker.
`default_nettype none

// Per-task burst penalty table. Each request beat carries one command (update,
// restart, clone restart, reset) for one task entry and yields one response beat
// with the new penalty, score, effective priority and a priority-changed flag.
// Items are processed one at a time, in the states from acceptance to the
// response register: the leading-one search over the 64-bit burst time (ST_LZ,
// ST_MSB), the fraction and offset (ST_FRAC), the scale multiplier (ST_MUL) and
// the table read-modify-write (ST_APPLY); the next item is accepted only after a
// return to ST_IDLE. One further item is accepted while a response waits; it then
// stalls in ST_APPLY until the response is taken. After reset a clearing pass
// zeroes every table entry, with req_bus.ready low; register writes are taken at
// any time and must be made while idle.
module burst_penalty_tracker_top
   import bpt_pkg::*;
#(
   parameter int NUM_TASKS = 64
) (
   input  wire logic clock,
   input  wire logic reset,
   bpt_req_if.sink   req_bus,
   bpt_rsp_if.source rsp_bus,
   bpt_csr_if.sink   csr_bus
);

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;
   logic          req_ready;

   bpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bpt_datapath #(
      .NUM_TASKS (NUM_TASKS)
   ) u_datapath (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus),
      .cmd   (cmd),
      .stat  (stat)
   );

   assign req_bus.ready = req_ready;

endmodule

`default_nettype wire

>>> dv/penalty_table_checker.sv
// Response checker for the burst penalty tracker: mirrors the table and checks each beat.
`timescale 1ns / 1ps

module penalty_table_checker
   import bpt_pkg::*;
#(
   parameter int NUM_TASKS = 64
) (
   input  wire logic clock,
   input  wire logic reset,
   bpt_req_if        req_mon,
   bpt_rsp_if        rsp_mon,
   bpt_csr_if        csr_mon,
   output int        pending_results,
   output int        mismatch_count,
   output int        checked_count
);

   typedef struct packed {
      logic [7:0] penalty;
      logic [5:0] score;
      logic [5:0] priority_level;
      logic       changed;
   } task_outcome_type;

   localparam int REPORT_LIMIT = 10;

   logic [7:0] history_tab [NUM_TASKS];
   logic [7:0] current_tab [NUM_TASKS];
   logic [7:0] penalty_tab [NUM_TASKS];
   logic [5:0] score_tab   [NUM_TASKS];

   logic        cfg_enable;
   logic        cfg_exclude;
   logic        cfg_rise;
   logic        cfg_fall;
   logic [6:0]  cfg_offset;
   logic [11:0] cfg_scale;

   task_outcome_type outcome_q [$];
   int faults  = 0;
   int checked = 0;

   // Position of the leading one plus one in the integer part, the eight bits
   // below the leading one as the fraction.
   function automatic logic [14:0] burst_log2_fixed(input logic [63:0] burst);
      int          lead;
      logic [63:0] aligned;
      lead = 0;
      for (int b = 0; b < 64; b++) begin
         if (burst[b]) lead = b + 1;
      end
      if (lead == 0) return 15'd0;
      aligned = burst << (64 - lead);
      return {lead[6:0], aligned[62:55]};
   endfunction

   function automatic logic [7:0] burst_to_penalty(input logic [63:0] burst);
      logic [14:0] greed;
      logic [14:0] tolerance;
      logic [14:0] excess;
      logic [31:0] scaled;
      greed     = burst_log2_fixed(burst);
      tolerance = {cfg_offset, 8'h00};
      excess    = (greed > tolerance) ? greed - tolerance : 15'd0;
      scaled    = ({17'd0, excess} * {20'd0, cfg_scale}) >> PROD_SHIFT;
      return (scaled < MAX_PENALTY) ? scaled[7:0] : MAX_PENALTY;
   endfunction

   function automatic logic [5:0] capped_priority(input logic [5:0] nice, input logic [5:0] score);
      logic [6:0] sum;
      sum = {1'b0, nice} + (cfg_enable ? {1'b0, score} : 7'd0);
      return (sum < PRIO_CAP) ? sum[5:0] : PRIO_CAP;
   endfunction

   function automatic logic [5:0] task_score_of(input logic [7:0] pen, input logic kthread);
      return (kthread && cfg_exclude) ? 6'd0 : pen[7:2];
   endfunction

   // Rises and falls are damped by separate shifts.
   function automatic void fold_history(input int slot);
      logic [7:0] fresh;
      logic [7:0] old;
      fresh = current_tab[slot];
      old   = history_tab[slot];
      if (fresh >= old) history_tab[slot] = old + ((fresh - old) >> cfg_rise);
      else history_tab[slot] = old - ((old - fresh) >> cfg_fall);
      current_tab[slot] = 8'd0;
      penalty_tab[slot] = history_tab[slot];
   endfunction

   always @(posedge clock) begin : track
      int               slot;
      logic [5:0]       prio_before;
      logic [7:0]       fresh;
      task_outcome_type predicted;
      task_outcome_type actual;
      if (reset) begin
         for (int t = 0; t < NUM_TASKS; t++) begin
            history_tab[t] = 8'd0;
            current_tab[t] = 8'd0;
            penalty_tab[t] = 8'd0;
            score_tab[t]   = 6'd0;
         end
         cfg_enable  = 1'b1;
         cfg_exclude = 1'b1;
         cfg_rise    = 1'b1;
         cfg_fall    = 1'b0;
         cfg_offset  = RST_OFFSET;
         cfg_scale   = RST_SCALE;
         outcome_q.delete();
      end else begin
         // A response always belongs to an earlier request, so it is checked
         // before this edge's request is predicted.
         if (rsp_mon.valid && rsp_mon.ready) begin
            actual = '{rsp_mon.penalty, rsp_mon.score, rsp_mon.effective_priority,
                       rsp_mon.priority_changed};
            if (outcome_q.size() == 0) begin
               if (faults < REPORT_LIMIT)
                  $display("[%0t] Response beat with nothing outstanding: penalty %0d score %0d",
                           $realtime, actual.penalty, actual.score);
               faults++;
            end else begin
               predicted = outcome_q.pop_front();
               checked++;
               if (actual.penalty !== predicted.penalty || actual.score !== predicted.score ||
                   actual.priority_level !== predicted.priority_level ||
                   actual.changed !== predicted.changed) begin
                  if (faults < REPORT_LIMIT) begin
                     $display("[%0t] Response %0d mismatch: expected penalty %0d score %0d %s %0d %s %0b",
                              $realtime, checked, predicted.penalty, predicted.score,
                              "priority", predicted.priority_level, "changed",
                              predicted.changed);
                     $display("   got penalty %0d score %0d priority %0d changed %0b",
                              actual.penalty, actual.score, actual.priority_level,
                              actual.changed);
                  end
                  faults++;
               end
            end
         end

         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_SCORE_ENABLE:    cfg_enable  = csr_mon.data[0];
               CSR_EXCLUDE_KTHREAD: cfg_exclude = csr_mon.data[0];
               CSR_SHIFT_RISE:      cfg_rise    = csr_mon.data[0];
               CSR_SHIFT_FALL:      cfg_fall    = csr_mon.data[0];
               CSR_PENALTY_OFFSET:  cfg_offset  = csr_mon.data[6:0];
               CSR_PENALTY_SCALE:   cfg_scale   = csr_mon.data[11:0];
               default: ;
            endcase
         end

         if (req_mon.valid && req_mon.ready) begin
            slot        = int'(req_mon.task_index) % NUM_TASKS;
            prio_before = capped_priority(req_mon.nice_index, score_tab[slot]);
            case (req_mon.cmd)
               CMD_UPDATE: begin
                  fresh             = burst_to_penalty(req_mon.burst_ns);
                  current_tab[slot] = fresh;
                  penalty_tab[slot] = (history_tab[slot] > fresh) ? history_tab[slot] : fresh;
                  score_tab[slot]   = task_score_of(penalty_tab[slot], req_mon.is_kernel_thread);
               end
               CMD_RESTART: begin
                  fold_history(slot);
                  score_tab[slot] = task_score_of(penalty_tab[slot], req_mon.is_kernel_thread);
               end
               CMD_CLONE: fold_history(slot);
               default: begin
                  history_tab[slot] = 8'd0;
                  current_tab[slot] = 8'd0;
                  penalty_tab[slot] = 8'd0;
                  score_tab[slot]   = 6'd0;
               end
            endcase
            predicted.penalty        = penalty_tab[slot];
            predicted.score          = score_tab[slot];
            predicted.priority_level = capped_priority(req_mon.nice_index, score_tab[slot]);
            predicted.changed        = (predicted.priority_level != prio_before);
            outcome_q.push_back(predicted);
         end
      end
      pending_results <= outcome_q.size();
      mismatch_count  <= faults;
      checked_count   <= checked;
   end

endmodule

>>> dv/testbench.sv
// Stimulus, register settings, pacing and verdict for the burst penalty tracker.
`timescale 1ns / 1ps

module testbench;
   import bpt_pkg::*;

   localparam int NUM_TASKS     = 64;
   localparam int STALL_LIMIT   = 5000;
   localparam int LONG_HOLD     = 90;
   localparam int SETTLE_CYCLES = 12;

   logic clock;
   logic reset;

   bpt_req_if req_bus ();
   bpt_rsp_if rsp_bus ();
   bpt_csr_if csr_bus ();

   int pending_results;
   int mismatch_count;
   int checked_count;

   bit idling_on     = 1'b1;
   int hold_requests = 0;
   int holds_served  = 0;
   int items_sent    = 0;
   int settings_used = 0;
   int cmd_tally [4] = '{0, 0, 0, 0};
   int quiet_cycles  = 0;

   burst_penalty_tracker_top #(.NUM_TASKS(NUM_TASKS)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   penalty_table_checker #(.NUM_TASKS(NUM_TASKS)) table_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .csr_mon         (csr_bus),
      .pending_results (pending_results),
      .mismatch_count  (mismatch_count),
      .checked_count   (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Ends the run when no beat moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Watchdog expired after %0d cycles without a beat, %0d responses outstanding",
                  quiet_cycles, pending_results);
         $display("Test completed with failures");
         $finish;
      end
   end

   // Response side: random stalls, plus a long hold-off when asked for.
   initial begin : sink_pacing
      int gap;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_served) begin
            holds_served++;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD - 1) @(posedge clock);
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            rsp_bus.ready <= 1'b0;
            repeat (gap - 1) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic offer_request(input cmd_type op, input logic [5:0] slot,
                                input logic [63:0] burst, input logic [5:0] nice,
                                input logic kthread);
      req_bus.valid            <= 1'b1;
      req_bus.cmd              <= op;
      req_bus.task_index       <= slot;
      req_bus.burst_ns         <= burst;
      req_bus.nice_index       <= nice;
      req_bus.is_kernel_thread <= kthread;
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
      items_sent++;
      cmd_tally[op]++;
   endtask

   task automatic sender_gap();
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (pending_results != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_beat(input csr_index_type reg_index, input logic [11:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= reg_index;
      csr_bus.data  <= value;
      do begin
         @(posedge clock);
      end while (!csr_bus.ready);
   endtask

   task automatic apply_setting(input bit enable, input bit exclude, input bit rise,
                                input bit fall, input logic [6:0] offset,
                                input logic [11:0] scale);
      drain_results();
      csr_beat(CSR_SCORE_ENABLE, {11'd0, enable});
      csr_beat(CSR_EXCLUDE_KTHREAD, {11'd0, exclude});
      csr_beat(CSR_SHIFT_RISE, {11'd0, rise});
      csr_beat(CSR_SHIFT_FALL, {11'd0, fall});
      csr_beat(CSR_PENALTY_OFFSET, {5'd0, offset});
      csr_beat(CSR_PENALTY_SCALE, scale);
      csr_bus.valid <= 1'b0;
      settings_used++;
   endtask

   // A burst whose leading one sits at bit lead-1 (zero for lead 0), random bits below it.
   function automatic logic [63:0] burst_with_lead(input int lead);
      logic [63:0] raw;
      if (lead == 0) return 64'd0;
      raw = {$urandom, $urandom};
      return (raw & ((64'd1 << lead) - 64'd1)) | (64'd1 << (lead - 1));
   endfunction

   // Most traffic lands on a handful of tasks so that history builds up.
   function automatic logic [5:0] pick_task();
      return ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, 7)) : 6'($urandom_range(0, 63));
   endfunction

   function automatic logic [5:0] pick_nice();
      return ($urandom_range(0, 9) == 0) ? 6'($urandom_range(40, 63)) : 6'($urandom_range(0, 39));
   endfunction

   task automatic random_single(input bit with_gap);
      cmd_type op;
      int      pick;
      pick = $urandom_range(0, 15);
      if (pick < 8) op = CMD_UPDATE;
      else if (pick < 12) op = CMD_RESTART;
      else if (pick < 14) op = CMD_CLONE;
      else op = CMD_RESET;
      offer_request(op, pick_task(), burst_with_lead($urandom_range(0, 64)), pick_nice(),
                    $urandom_range(0, 3) == 0);
      if (with_gap) sender_gap();
   endtask

   // One task's life: a few growing bursts, then a restart or a clone.
   task automatic burst_episode();
      logic [5:0] slot;
      logic [5:0] nice;
      logic       kthread;
      int         lead;
      slot    = pick_task();
      nice    = pick_nice();
      kthread = ($urandom_range(0, 3) == 0);
      lead    = $urandom_range(16, 48);
      repeat ($urandom_range(1, 4)) begin
         lead = lead + $urandom_range(0, 8);
         if (lead > 64) lead = 64;
         offer_request(CMD_UPDATE, slot, burst_with_lead(lead), nice, kthread);
         sender_gap();
      end
      offer_request(($urandom_range(0, 3) == 0) ? CMD_CLONE : CMD_RESTART, slot,
                    burst_with_lead($urandom_range(0, 64)), nice, kthread);
      sender_gap();
   endtask

   task automatic run_phase(input int quota);
      int start;
      start = items_sent;
      while (items_sent - start < quota) begin
         if ($urandom_range(0, 4) == 0) random_single(1'b1);
         else burst_episode();
      end
   endtask

   // The response side stalls for a long stretch while requests keep coming,
   // then the sender waits until every response is back.
   task automatic stress_backpressure();
      hold_requests++;
      repeat (16) random_single(1'b0);
      drain_results();
   endtask

   task automatic run_directed();
      offer_request(CMD_UPDATE, 6'd0, 64'd0, 6'd0, 1'b0);
      offer_request(CMD_UPDATE, 6'd0, '1, 6'd39, 1'b0);
      offer_request(CMD_UPDATE, 6'd0, '1, 6'd0, 1'b0);
      sender_gap();
      offer_request(CMD_RESTART, 6'd0, 64'd0, 6'd0, 1'b0);
      offer_request(CMD_UPDATE, 6'd0, 64'd1, 6'd5, 1'b0);
      offer_request(CMD_CLONE, 6'd0, 64'd0, 6'd5, 1'b0);
      offer_request(CMD_RESTART, 6'd0, 64'd0, 6'd5, 1'b0);
      sender_gap();
      offer_request(CMD_UPDATE, 6'd1, '1, 6'd10, 1'b1);
      offer_request(CMD_UPDATE, 6'd1, 64'h8000_0000_0000_0000, 6'd10, 1'b0);
      offer_request(CMD_RESET, 6'd1, 64'd0, 6'd10, 1'b0);
      // Just at and just above the default offset.
      offer_request(CMD_UPDATE, 6'd63, 64'h0000_0000_0080_0000, 6'd63, 1'b0);
      offer_request(CMD_UPDATE, 6'd63, 64'h0000_0000_0100_0000, 6'd63, 1'b0);
      offer_request(CMD_RESTART, 6'd63, 64'd0, 6'd63, 1'b1);
      offer_request(CMD_RESET, 6'd63, '1, 6'd0, 1'b1);
      sender_gap();
      offer_request(CMD_UPDATE, 6'd2, 64'h5555_5555_5555_5555, 6'd20, 1'b0);
      offer_request(CMD_UPDATE, 6'd2, 64'hAAAA_AAAA_AAAA_AAAA, 6'd20, 1'b0);
      offer_request(CMD_CLONE, 6'd2, 64'd0, 6'd20, 1'b1);
      offer_request(CMD_RESET, 6'd5, 64'd0, 6'd39, 1'b0);
   endtask

   initial begin : stimulus
      reset                    <= 1'b1;
      req_bus.valid            <= 1'b0;
      req_bus.cmd              <= CMD_UPDATE;
      req_bus.task_index       <= 6'd0;
      req_bus.burst_ns         <= 64'd0;
      req_bus.nice_index       <= 6'd0;
      req_bus.is_kernel_thread <= 1'b0;
      csr_bus.valid            <= 1'b0;
      csr_bus.index            <= CSR_SCORE_ENABLE;
      csr_bus.data             <= 12'd0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      apply_setting(1'b0, 1'b0, 1'b0, 1'b0, 7'd0, 12'd0);
      run_phase(150);
      apply_setting(1'b1, 1'b1, 1'b1, 1'b1, 7'd127, 12'd4095);
      run_phase(200);
      idling_on = 1'b0;
      apply_setting(1'b1, 1'b0, 1'b0, 1'b1, 7'd0, 12'd4095);
      run_phase(200);
      idling_on = 1'b1;
      apply_setting(1'b1, 1'b1, 1'b1, 1'b0, RST_OFFSET, RST_SCALE);
      run_phase(120);
      stress_backpressure();
      run_phase(110);
      apply_setting(1'b0, 1'b1, 1'b0, 1'b0, 7'd64, 12'd4095);
      run_phase(150);
      repeat (2) begin
         apply_setting(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       7'($urandom_range(0, 40)), 12'($urandom_range(256, 4095)));
         run_phase(120);
         stress_backpressure();
         run_phase(110);
      end
      idling_on = 1'b0;
      apply_setting(1'b1, 1'b1, 1'b1, 1'b0, 7'd16, 12'd2048);
      run_phase(250);
      drain_results();

      $display("Sent %0d requests under %0d register settings; %0d responses checked.",
               items_sent, settings_used, checked_count);
      $display("Commands: %0d updates, %0d restarts, %0d clones, %0d task resets.",
               cmd_tally[CMD_UPDATE], cmd_tally[CMD_RESTART], cmd_tally[CMD_CLONE],
               cmd_tally[CMD_RESET]);
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
